>>> design/wsib_pkg.sv
package wsib_pkg;

   localparam int POS_BITS_DEF   = 32;
   localparam int SCORE_BITS_DEF = 16;

   // fixed field widths on the ports
   localparam int POS_FIELD_BITS   = 32;
   localparam int SCORE_FIELD_BITS = 16;
   localparam int REQ_DATA_BITS    = 2 * POS_FIELD_BITS + 2 * SCORE_FIELD_BITS;
   localparam int RSP_DATA_BITS    = 2 * POS_FIELD_BITS;
   localparam int CSR_INDEX_BITS   = 1;
   localparam int CSR_DATA_BITS    = SCORE_FIELD_BITS;

   typedef enum logic [0:0] {
      OP_WINDOW = 1'b0,
      OP_FLUSH  = 1'b1
   } op_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_CUTOFF = 1'b0,
      CSR_EXTEND = 1'b1
   } csr_index_type;

endpackage

>>> design/wsib_decide.sv
module wsib_decide import wsib_pkg::*; #(
   parameter int POS_BITS   = POS_BITS_DEF,
   parameter int SCORE_BITS = SCORE_BITS_DEF
) (
   input  op_type                operation,
   input  logic [POS_BITS-1:0]   win_start,
   input  logic [POS_BITS-1:0]   win_end,
   input  logic [SCORE_BITS-1:0] window_score,
   input  logic [SCORE_BITS-1:0] trigger_value,
   input  logic [SCORE_BITS-1:0] cut_level,
   input  logic [SCORE_BITS-1:0] extend_threshold,
   input  logic [POS_BITS-1:0]   run_first,
   input  logic [POS_BITS-1:0]   run_last,
   input  logic [POS_BITS-1:0]   covered_last,
   output logic [POS_BITS-1:0]   run_first_next,
   output logic [POS_BITS-1:0]   run_last_next,
   output logic [POS_BITS-1:0]   covered_last_next,
   output logic                  emit
);

   logic              open;
   logic              gap;
   logic [POS_BITS:0] covered_plus_one;

   assign open             = run_last > run_first;
   // one extra bit so covered_last + 1 never wraps
   assign covered_plus_one = {1'b0, covered_last} + {{POS_BITS{1'b0}}, 1'b1};
   assign gap              = {1'b0, win_start} > covered_plus_one;

   always_comb begin
      run_first_next    = run_first;
      run_last_next     = run_last;
      covered_last_next = covered_last;
      emit              = 1'b0;
      unique case (operation)
         OP_FLUSH: begin
            emit              = open;
            run_first_next    = '0;
            run_last_next     = '0;
            covered_last_next = '0;
         end
         default: begin
            if (window_score < extend_threshold) begin
               if (open && (win_start > covered_last)) begin
                  emit              = 1'b1;
                  run_first_next    = '0;
                  run_last_next     = '0;
                  covered_last_next = '0;
               end
            end else if (trigger_value < cut_level) begin
               if (open) begin
                  if (gap) begin
                     emit              = 1'b1;
                     run_first_next    = '0;
                     run_last_next     = '0;
                     covered_last_next = '0;
                  end else begin
                     covered_last_next = win_end;
                  end
               end
            end else begin
               // masked window: open a run, or restart it after a gap
               if (!open || gap) begin
                  run_first_next = win_start;
               end
               emit              = open && gap;
               run_last_next     = win_end;
               covered_last_next = win_end;
            end
         end
      endcase
   end

endmodule

>>> design/window_score_interval_builder.sv
// Window score interval builder.
// req_* carries one scored window per item (or an end-of-sequence flush,
// selected by req_tuser); rsp_* carries closed masked intervals, zero or
// one per input item. csr_we/csr_index/csr_wdata write the cutoff score
// (index 0) and the extension threshold (index 1); write them only while
// the block is idle.
// An accepted item sits in the input register while the run decision and
// state update are made from it, and any interval lands in the output
// register as the item advances; rsp_tvalid is driven from that register.
// One item per cycle is sustained while rsp_tready does not stall; the only
// feedback is the open run state, updated as each item advances.
// Items that close no run produce nothing on rsp_*.
// When rsp_tready is low with a result held, the input register holds its
// item and req_tready drops once it is full; nothing is lost.
// Synchronous reset clears the open run, both thresholds and all valids.
module window_score_interval_builder import wsib_pkg::*; #(
   parameter int POS_BITS   = POS_BITS_DEF,
   parameter int SCORE_BITS = SCORE_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   // win_start[31:0], win_end[63:32], window_score[79:64], trigger_value[95:80]
   input  logic [REQ_DATA_BITS-1:0]  req_tdata,
   // operation
   input  logic                      req_tuser,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // interval_start[31:0], interval_end[63:32]
   output logic [RSP_DATA_BITS-1:0]  rsp_tdata,
   input  logic                      csr_we,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   localparam int P = POS_FIELD_BITS;
   localparam int S = SCORE_FIELD_BITS;

   logic                  in_valid_ff;
   op_type                in_op_ff;
   logic [POS_BITS-1:0]   in_start_ff;
   logic [POS_BITS-1:0]   in_end_ff;
   logic [SCORE_BITS-1:0] in_mean_ff;
   logic [SCORE_BITS-1:0] in_trig_ff;

   logic [SCORE_BITS-1:0] cutoff_ff;
   logic [SCORE_BITS-1:0] extend_ff;

   logic [POS_BITS-1:0]   run_first_ff;
   logic [POS_BITS-1:0]   run_last_ff;
   logic [POS_BITS-1:0]   covered_ff;
   logic [POS_BITS-1:0]   run_first_in;
   logic [POS_BITS-1:0]   run_last_in;
   logic [POS_BITS-1:0]   covered_in;
   logic                  emit;

   logic                  rsp_valid_ff;
   logic [P-1:0]          rsp_start_ff;
   logic [P-1:0]          rsp_end_ff;

   logic                  out_free;
   logic                  advance;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || out_free;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_end_ff, rsp_start_ff};

   wsib_decide #(
      .POS_BITS   (POS_BITS),
      .SCORE_BITS (SCORE_BITS)
   ) u_decide (
      .operation         (in_op_ff),
      .win_start         (in_start_ff),
      .win_end           (in_end_ff),
      .window_score      (in_mean_ff),
      .trigger_value     (in_trig_ff),
      .cut_level         (cutoff_ff),
      .extend_threshold  (extend_ff),
      .run_first         (run_first_ff),
      .run_last          (run_last_ff),
      .covered_last      (covered_ff),
      .run_first_next    (run_first_in),
      .run_last_next     (run_last_in),
      .covered_last_next (covered_in),
      .emit              (emit)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cutoff_ff <= '0;
         extend_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_CUTOFF: cutoff_ff <= SCORE_BITS'(csr_wdata);
            CSR_EXTEND: extend_ff <= SCORE_BITS'(csr_wdata);
            default: ;
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_op_ff    <= op_type'(req_tuser);
         in_start_ff <= POS_BITS'(req_tdata[P-1:0]);
         in_end_ff   <= POS_BITS'(req_tdata[2*P-1:P]);
         in_mean_ff  <= SCORE_BITS'(req_tdata[2*P+S-1:2*P]);
         in_trig_ff  <= SCORE_BITS'(req_tdata[2*P+2*S-1:2*P+S]);
      end
   end

   // run state, advanced once per item
   always_ff @(posedge clock) begin
      if (reset) begin
         run_first_ff <= '0;
         run_last_ff  <= '0;
         covered_ff   <= '0;
      end else if (advance) begin
         run_first_ff <= run_first_in;
         run_last_ff  <= run_last_in;
         covered_ff   <= covered_in;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= advance && emit;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && emit) begin
         rsp_start_ff <= P'(run_first_ff);
         rsp_end_ff   <= P'(run_last_ff);
      end
   end

endmodule

>>> tb/window_score_interval_builder_test.sv
`timescale 1ns / 100ps

module window_score_interval_builder_test;
   import wsib_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int SETTLE_CYCLES = 6;

   typedef struct {
      op_type      op;
      logic [31:0] first_pos;
      logic [31:0] last_pos;
      logic [15:0] mean_score;
      logic [15:0] trig_score;
   } window_item_type;

   logic                      clock;
   logic                      reset;
   logic                      req_tvalid;
   logic                      req_tready;
   logic [REQ_DATA_BITS-1:0]  req_tdata;
   logic                      req_tuser;
   logic                      rsp_tvalid;
   logic                      rsp_tready;
   logic [RSP_DATA_BITS-1:0]  rsp_tdata;
   logic                      csr_we;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_wdata;

   window_item_type pending_windows[$];
   logic [63:0]     intervals_due[$];
   window_item_type next_window;
   logic [63:0]     due_interval;
   logic            req_taken;
   int              burst_left;
   int              gap_left;
   int              ready_left;
   int              stall_left;
   int              cycle_count;
   int              errors;

   // predictor state and register mirror
   logic [31:0] run_first;
   logic [31:0] run_last;
   logic [31:0] cover_last;
   logic [15:0] cutoff_level;
   logic [15:0] extend_level;

   window_score_interval_builder uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic track_run(input op_type op, input logic [31:0] ws, input logic [31:0] we,
                            input logic [15:0] mean, input logic [15:0] trig);
      logic        open_run;
      logic [32:0] reach;
      open_run = run_last > run_first;
      // one extra bit so covered end plus one never wraps
      reach = {1'b0, cover_last} + 33'd1;
      if (op == OP_FLUSH) begin
         if (open_run)
            intervals_due.insert(intervals_due.size(), {run_last, run_first});
         run_first = '0;
         run_last = '0;
         cover_last = '0;
      end else if (mean < extend_level) begin
         if (open_run && ws > cover_last) begin
            intervals_due.insert(intervals_due.size(), {run_last, run_first});
            run_first = '0;
            run_last = '0;
            cover_last = '0;
         end
      end else if (trig < cutoff_level) begin
         if (open_run) begin
            if ({1'b0, ws} > reach) begin
               intervals_due.insert(intervals_due.size(), {run_last, run_first});
               run_first = '0;
               run_last = '0;
               cover_last = '0;
            end else begin
               cover_last = we;
            end
         end
      end else begin
         if (!open_run) begin
            run_first = ws;
         end else if ({1'b0, ws} > reach) begin
            intervals_due.insert(intervals_due.size(), {run_last, run_first});
            run_first = ws;
         end
         run_last = we;
         cover_last = we;
      end
   endtask

   task automatic add_item(input op_type op, input logic [31:0] ws, input logic [31:0] we,
                           input logic [15:0] mean, input logic [15:0] trig);
      window_item_type w;
      w.op = op;
      w.first_pos = ws;
      w.last_pos = we;
      w.mean_score = mean;
      w.trig_score = trig;
      pending_windows.insert(pending_windows.size(), w);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [15:0] value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      if (idx == CSR_CUTOFF)
         cutoff_level = value;
      else
         extend_level = value;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // wait until every item is taken and every interval has come out
   task automatic drain;
      while (pending_windows.size() != 0 || req_tvalid || intervals_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [15:0] pick_score(input logic [15:0] level, input int pass_pct);
      logic [16:0] raised;
      logic [15:0] value;
      if ($urandom_range(0, 7) == 0) begin
         value = 16'($urandom);
      end else if ($urandom_range(1, 100) <= pass_pct) begin
         raised = {1'b0, level} + 17'($urandom_range(0, 3));
         value = raised[16] ? 16'hFFFF : raised[15:0];
      end else if (level == 16'h0000) begin
         value = 16'h0000;
      end else begin
         value = level - 16'd1;
         if (level > 16'd3)
            value = value - 16'($urandom_range(0, 2));
      end
      return value;
   endfunction

   task automatic add_random_windows(input int count, input logic [15:0] cut,
                                     input logic [15:0] ext);
      int          roll;
      int          jump;
      logic [31:0] cursor;
      logic [31:0] ws;
      logic [31:0] we;
      roll = $urandom_range(0, 3);
      if (roll == 0)
         cursor = $urandom_range(0, 64);
      else if (roll == 1)
         cursor = 32'hFFFF_FF00 + $urandom_range(0, 200);
      else
         cursor = $urandom;
      for (int i = 0; i < count; i++) begin
         roll = $urandom_range(0, 99);
         if (roll < 4) begin
            add_item(OP_FLUSH, $urandom, $urandom, 16'($urandom), 16'($urandom));
         end else if (roll < 12) begin
            add_item(OP_WINDOW, $urandom, $urandom, 16'($urandom), 16'($urandom));
         end else begin
            jump = $urandom_range(0, 99);
            if (jump < 15)
               ws = cursor - $urandom_range(0, 8);
            else if (jump < 65)
               ws = cursor + $urandom_range(0, 1);
            else if (jump < 88)
               ws = cursor + $urandom_range(2, 4);
            else
               ws = cursor + $urandom_range(5, 5000);
            if ($urandom_range(0, 29) == 0)
               we = ws - $urandom_range(1, 6);
            else
               we = ws + $urandom_range(0, 24);
            add_item(OP_WINDOW, ws, we, pick_score(ext, 85), pick_score(cut, 55));
            cursor = we;
         end
      end
   endtask

   // sender: bursts of items with random gaps
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         if (gap_left > 0) begin
            gap_left = gap_left - 1;
            req_tvalid <= 1'b0;
         end else if (pending_windows.size() > 0) begin
            next_window = pending_windows.pop_front();
            req_tvalid <= 1'b1;
            req_tuser <= next_window.op;
            req_tdata <= {next_window.trig_score, next_window.mean_score,
                          next_window.last_pos, next_window.first_pos};
            if (burst_left > 0) begin
               burst_left = burst_left - 1;
            end else begin
               burst_left = $urandom_range(1, 24);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // receiver: ready stretches broken by short stalls, now and then a long clean run
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left = stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (ready_left > 0) begin
         ready_left = ready_left - 1;
         rsp_tready <= 1'b1;
      end else begin
         if ($urandom_range(0, 5) == 0) begin
            ready_left = $urandom_range(40, 120);
            stall_left = 0;
         end else begin
            ready_left = $urandom_range(0, 12);
            stall_left = $urandom_range(1, 6);
         end
         rsp_tready <= 1'b1;
      end
   end

   // predict on accepted items, check accepted intervals
   always @(posedge clock) begin
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_tvalid && req_tready;
         if (req_tvalid && req_tready)
            track_run(op_type'(req_tuser), req_tdata[31:0], req_tdata[63:32],
                      req_tdata[79:64], req_tdata[95:80]);
         if (rsp_tvalid && rsp_tready) begin
            if (intervals_due.size() == 0) begin
               $display("%0t: unexpected interval: expected none, got start %h end %h",
                        $time, rsp_tdata[31:0], rsp_tdata[63:32]);
               errors = errors + 1;
            end else begin
               due_interval = intervals_due.pop_front();
               if (rsp_tdata[31:0] !== due_interval[31:0]) begin
                  $display("%0t: interval_start mismatch: expected %h, got %h",
                           $time, due_interval[31:0], rsp_tdata[31:0]);
                  errors = errors + 1;
               end
               if (rsp_tdata[63:32] !== due_interval[63:32]) begin
                  $display("%0t: interval_end mismatch: expected %h, got %h",
                           $time, due_interval[63:32], rsp_tdata[63:32]);
                  errors = errors + 1;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout at %0t", $time);
         $display("window_score_interval_builder regression: fail");
         $finish;
      end
   end

   initial begin
      logic [15:0] cut;
      logic [15:0] ext;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = 1'b0;
      rsp_tready = 1'b0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_taken = 1'b0;
      burst_left = 0;
      gap_left = 0;
      ready_left = 0;
      stall_left = 0;
      cycle_count = 0;
      errors = 0;
      run_first = '0;
      run_last = '0;
      cover_last = '0;
      cutoff_level = '0;
      extend_level = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      write_csr(CSR_CUTOFF, 16'd100);
      write_csr(CSR_EXTEND, 16'd50);
      // open, extend cover, close on low mean past the cover
      add_item(OP_WINDOW, 32'd10, 32'd20, 16'd60, 16'd200);
      add_item(OP_WINDOW, 32'd15, 32'd30, 16'd60, 16'd10);
      add_item(OP_WINDOW, 32'd31, 32'd40, 16'd60, 16'd10);
      add_item(OP_WINDOW, 32'd45, 32'd50, 16'd10, 16'd200);
      // single-position run is never open; flush of it emits nothing
      add_item(OP_WINDOW, 32'd100, 32'd100, 16'd60, 16'd200);
      add_item(OP_FLUSH, 32'd0, 32'd0, 16'd0, 16'd0);
      // top of the position range: covered end plus one must not wrap
      add_item(OP_WINDOW, 32'hFFFF_FFF0, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
      add_item(OP_WINDOW, 32'hFFFF_FFFF, 32'h0000_0000, 16'd60, 16'd200);
      add_item(OP_FLUSH, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
      // masked window past a gap closes and reopens; unmasked past a gap closes
      add_item(OP_WINDOW, 32'd5, 32'd9, 16'd60, 16'd200);
      add_item(OP_WINDOW, 32'd20, 32'd25, 16'd60, 16'd200);
      add_item(OP_WINDOW, 32'd27, 32'd30, 16'd60, 16'd50);
      add_item(OP_WINDOW, 32'h0000_0000, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
      add_item(OP_WINDOW, 32'hFFFF_FFFF, 32'd3, 16'd0, 16'd200);
      add_item(OP_WINDOW, 32'hFFFF_FFFF, 32'd3, 16'd60, 16'd0);
      add_item(OP_WINDOW, 32'd4, 32'd8, 16'd49, 16'd0);
      // reversed window, then a flush with junk fields emits the open run
      add_item(OP_WINDOW, 32'd7, 32'd3, 16'd60, 16'd200);
      add_item(OP_WINDOW, 32'd50, 32'd60, 16'd50, 16'd100);
      add_item(OP_FLUSH, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
      add_item(OP_FLUSH, 32'h0000_0000, 32'h0000_0000, 16'h0000, 16'h0000);
      drain();

      for (int phase = 0; phase < 8; phase++) begin
         case (phase)
            0: begin
               cut = 16'h0000;
               ext = 16'h0000;
            end
            1: begin
               cut = 16'hFFFF;
               ext = 16'hFFFF;
            end
            2: begin
               cut = 16'hFFFF;
               ext = 16'h0000;
            end
            3: begin
               cut = 16'h8000;
               ext = 16'h7FFF;
            end
            default: begin
               cut = 16'($urandom);
               ext = 16'($urandom);
            end
         endcase
         write_csr(CSR_CUTOFF, cut);
         write_csr(CSR_EXTEND, ext);
         add_random_windows(135, cut, ext);
         drain();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (errors == 0)
         $display("window_score_interval_builder regression: pass");
      else
         $display("window_score_interval_builder regression: fail");
      $finish;
   end

endmodule
